// ----- src/crc8ck_pkg.sv -----
// Package for the CRC-8 chained key keystream block.
// Holds shared widths, register codes, the configuration struct and the CRC-8 step function.
// No dependencies.
`timescale 1ns / 1ps

package crc8ck_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_MAX_DEF = 16;
    localparam int POS_W       = 4;
    localparam int LEN_W       = 5;
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 5;

    localparam logic [7:0] CRC8_POLY = 8'h8C;

    // register index codes (paddr[4:3])
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;
    localparam logic [1:0] REG_NONE     = 2'd3;

    typedef struct packed {
        logic [REG_W-1:0] key_low;
        logic [REG_W-1:0] key_high;
        logic [LEN_W-1:0] key_length;
    } t_key_cfg;

    // eight reflected shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- src/crc8_chained_key_keystream_xor.sv -----
// Top level of the CRC-8 chained key keystream XOR block.
// Instantiates crc8ck_cfg and crc8ck_core; depends on crc8ck_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one packet byte per transaction
//   with the region length and a first-byte mark. Output channel
//   (o_valid / i_ready) returns one masked byte per input transaction, in order.
//   Masking and unmasking are the same operation.
//   Configuration: APB-style port, 64-bit registers at byte addresses
//   0 (key_low), 8 (key_high), 16 (key_length); pready is tied high.
//   Write the key only while no transaction is in flight.
// Pipeline and throughput:
//   A byte is captured in the input register, then the keystream step
//   (key byte add, chain XOR, eight CRC-8 shift steps) runs combinationally
//   into the result register, which drives o_valid.
//   One byte per cycle sustained while i_ready stays high; the chain
//   register feeds back through that combinational step.
// Reset (synchronous, active low): key registers clear, key_length = 1,
//   chain value, key position and length base clear, both stages empty.
// Stall: when i_ready is low the result holds; one more byte can still sit
//   in the input register, after which o_ready drops.
`timescale 1ns / 1ps

module crc8_chained_key_keystream_xor #(
    parameter int KEY_MAX = crc8ck_pkg::KEY_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crc8ck_pkg::ADDR_W-1:0] paddr,
    input  logic [crc8ck_pkg::REG_W-1:0]  pwdata,
    output logic [crc8ck_pkg::REG_W-1:0]  prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic [15:0]                   i_region_len,
    input  logic                          i_first,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_byte
);
    import crc8ck_pkg::*;

    t_key_cfg key_cfg;

    // register file: key bytes and key length
    crc8ck_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (key_cfg)
    );

    // keystream datapath with its running chain state
    crc8ck_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (key_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_region_len (i_region_len),
        .i_first      (i_first),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte)
    );

endmodule

// ----- src/crc8ck_cfg.sv -----
// Configuration register file on an APB-style port.
// Holds key_low, key_high and key_length; depends on crc8ck_pkg.
`timescale 1ns / 1ps

module crc8ck_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crc8ck_pkg::ADDR_W-1:0] paddr,
    input  logic [crc8ck_pkg::REG_W-1:0]  pwdata,
    output logic [crc8ck_pkg::REG_W-1:0]  prdata,
    output logic                          pready,
    output crc8ck_pkg::t_key_cfg          o_cfg
);
    import crc8ck_pkg::*;

    logic [REG_W-1:0] r_key_low;
    logic [REG_W-1:0] r_key_high;
    logic [LEN_W-1:0] r_key_length;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= LEN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_LOW:  r_key_low    <= pwdata;
                REG_KEY_HIGH: r_key_high   <= pwdata;
                REG_KEY_LEN:  r_key_length <= pwdata[LEN_W-1:0];
                REG_NONE:     ;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LEN:  prdata = {{(REG_W-LEN_W){1'b0}}, r_key_length};
            REG_NONE:     prdata = '0;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.key_low    = r_key_low;
    assign o_cfg.key_high   = r_key_high;
    assign o_cfg.key_length = r_key_length;

endmodule

// ----- src/crc8ck_core.sv -----
// Datapath: input register, keystream step with chained CRC-8, result register.
// Depends on crc8ck_pkg.
`timescale 1ns / 1ps

module crc8ck_core #(
    parameter int KEY_MAX = crc8ck_pkg::KEY_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crc8ck_pkg::t_key_cfg i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_region_len,
    input  logic                 i_first,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte
);
    import crc8ck_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_data;
    logic [7:0]  r_rlen_lo;
    logic        r_first;
    // running state
    logic [7:0]       r_chain;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_base;
    // result stage
    logic        r_out_valid;
    logic [7:0]  r_out_byte;

    logic                    advance;
    logic [LEN_W-1:0]        eff_len;
    logic [8*KEY_BYTES-1:0]  key_all;
    logic [7:0]              base_use;
    logic [7:0]              chain_use;
    logic [POS_W-1:0]        pos_use;
    logic [7:0]              key_b;
    logic [7:0]              n_chain;
    logic [POS_W:0]          pos_inc;
    logic [POS_W-1:0]        n_pos;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign key_all = {i_cfg.key_high, i_cfg.key_low};

    always_comb begin
        if (i_cfg.key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_cfg.key_length > LEN_W'(KEY_MAX)) begin
            eff_len = LEN_W'(KEY_MAX);
        end else begin
            eff_len = i_cfg.key_length;
        end
    end

    always_comb begin
        base_use  = r_first ? (r_rlen_lo + 8'(eff_len)) : r_base;
        chain_use = r_first ? 8'd0 : r_chain;
        pos_use   = r_first ? '0 : r_pos;
        key_b     = key_all[{pos_use, 3'b000} +: 8];
        n_chain   = crc8_byte(chain_use ^ (key_b + base_use));
        pos_inc   = {1'b0, pos_use} + (POS_W+1)'(1);
        n_pos     = (pos_inc >= (POS_W+1)'(eff_len)) ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
            r_pos       <= '0;
            r_base      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_chain     <= n_chain;
                r_pos       <= n_pos;
                r_base      <= base_use;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data    <= i_data_byte;
            r_rlen_lo <= i_region_len[7:0];
            r_first   <= i_first;
        end
        if (advance) begin
            r_out_byte <= r_data ^ n_chain;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

endmodule
